// File: rtl/core/cfr_pkg.sv
`default_nettype none

package cfr_pkg;

  // Input tdata: rx_byte, req_length, expected_crc
  localparam int IN_TDATA_W  = 72;
  // Input tuser: kind, has_byte
  localparam int IN_TUSER_W  = 3;
  // Output tdata: status, error_cause, finished_buffer, finished_length, computed_crc
  localparam int OUT_TDATA_W = 56;

  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [1:0]  NO_FINISHED = 2'd2;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_START   = 2'd1,
    KIND_CANCEL  = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_SUCCESS  = 2'd0,
    ST_PROGRESS = 2'd1,
    ST_ERROR    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    CAUSE_NONE        = 4'd0,
    CAUSE_NO_TRANSFER = 4'd1,
    CAUSE_BLOCK_LONG  = 4'd2,
    CAUSE_TOO_MANY    = 4'd3,
    CAUSE_BUSY        = 4'd4,
    CAUSE_TOO_LARGE   = 4'd5,
    CAUSE_CANCELLED   = 4'd6,
    CAUSE_CRC         = 4'd7,
    CAUSE_BAD_CMD     = 4'd8
  } cause_e;

  // Packed so that status lands in the lowest bits
  typedef struct packed {
    logic [31:0] computed_crc;
    logic [14:0] finished_length;
    logic        finished_buffer;
    cause_e      error_cause;
    status_e     status;
  } result_t;

  // Reflected CRC-32 update by one byte, state kept in non-inverted form
  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] r;
    r = ~crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return ~r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/crc_checked_file_receiver_unit.sv
// Results are registered in the output register, or in the skid stage if that is occupied.
// Throughput: one item per cycle unless stalled; all state updates, the CRC byte step
// and the store write complete in the accepting cycle; the store has a single write port.
// The input stalls only when both the output register and the skid stage hold results.
// Reset (rst_ni low, asynchronous) clears all control state; the file store is not cleared.
`default_nettype none

module crc_checked_file_receiver_unit #(
  parameter int FILE_MAX_BYTES  = 16384,
  parameter int BLOCK_MAX_BYTES = 128
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [7:0] rx_byte, [39:8] req_length, [71:40] expected_crc
  input  wire logic [cfr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] kind, [2] has_byte
  input  wire logic [cfr_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  // block_end
  input  wire logic                             s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [1:0] status, [5:2] error_cause, [6] finished_buffer,
  // [21:7] finished_length, [53:22] computed_crc, [55:54] zero
  output logic [cfr_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

  localparam int ADDR_W = $clog2(2 * FILE_MAX_BYTES);

  logic             accept;
  logic             res_valid;
  cfr_pkg::result_t res;
  cfr_pkg::result_t out_res;
  logic             space;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]       mem_data;

  // Take an item whenever the skid stage is free
  assign s_axis_tready = space;
  assign accept        = s_axis_tvalid && space;

  cfr_core #(
    .FILE_MAX_BYTES (FILE_MAX_BYTES),
    .BLOCK_MAX_BYTES(BLOCK_MAX_BYTES)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .kind_i        (cfr_pkg::kind_e'(s_axis_tuser[1:0])),
    .rx_byte_i     (s_axis_tdata[7:0]),
    .has_byte_i    (s_axis_tuser[2]),
    .block_end_i   (s_axis_tlast),
    .req_length_i  (s_axis_tdata[39:8]),
    .expected_crc_i(s_axis_tdata[71:40]),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .mem_we_o      (mem_we),
    .mem_addr_o    (mem_addr),
    .mem_data_o    (mem_data)
  );

  // Two halves of FILE_MAX_BYTES each; write-only from this block
  cfr_ram #(
    .WIDTH(8),
    .DEPTH(2 * FILE_MAX_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_addr),
    .wdata_i(mem_data),
    .re_i   (1'b0),
    .raddr_i('0),
    .rdata_o()
  );

  cfr_skid u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .space_o    (space),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_res)
  );

  assign m_axis_tdata = {2'b00, out_res};

endmodule

`default_nettype wire

// File: rtl/core/cfr_ram.sv
`default_nettype none

module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cfr_core.sv
`default_nettype none

module cfr_core #(
  parameter int FILE_MAX_BYTES  = 16384,
  parameter int BLOCK_MAX_BYTES = 128,
  localparam int ADDR_W = $clog2(2 * FILE_MAX_BYTES)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire cfr_pkg::kind_e     kind_i,
  input  wire logic [7:0]         rx_byte_i,
  input  wire logic               has_byte_i,
  input  wire logic               block_end_i,
  input  wire logic [31:0]        req_length_i,
  input  wire logic [31:0]        expected_crc_i,
  output logic                    res_valid_o,
  output cfr_pkg::result_t        res_o,
  output logic                    mem_we_o,
  output logic [ADDR_W-1:0]       mem_addr_o,
  output logic [7:0]              mem_data_o
);

  localparam int CNT_W = $clog2(FILE_MAX_BYTES + BLOCK_MAX_BYTES + 2);
  localparam int BLK_W = $clog2(BLOCK_MAX_BYTES + 2);
  localparam int LEN_W = $clog2(FILE_MAX_BYTES + 1);
  localparam logic [BLK_W-1:0]  BlkMax  = BLK_W'(BLOCK_MAX_BYTES);
  localparam logic [CNT_W-1:0]  FileMax = CNT_W'(FILE_MAX_BYTES);
  localparam logic [ADDR_W-1:0] HalfOff = ADDR_W'(FILE_MAX_BYTES);

  logic              active_q, active_d;
  logic              half_q, half_d;
  logic [1:0]        fin_q, fin_d;
  logic [CNT_W-1:0]  comm_q, comm_d;
  logic [BLK_W-1:0]  blk_q, blk_d;
  logic [31:0]       exp_len_q, exp_len_d;
  logic [31:0]       exp_crc_q, exp_crc_d;
  logic [31:0]       crc_q, crc_d;
  logic [LEN_W-1:0]  good_q, good_d;

  logic              take;
  logic [CNT_W-1:0]  offset;
  logic [BLK_W-1:0]  blk_new;
  logic [CNT_W-1:0]  total;
  logic [31:0]       crc_new;
  logic              len_gt;
  logic              len_eq;
  cfr_pkg::status_e  st;
  cfr_pkg::cause_e   cause;
  logic [31:0]       res_crc;

  always_comb begin
    take    = has_byte_i && (blk_q <= BlkMax);
    offset  = comm_q + CNT_W'(blk_q);
    blk_new = blk_q + BLK_W'(take);
    total   = comm_q + CNT_W'(blk_new);
    crc_new = take ? cfr_pkg::crc32_byte(crc_q, rx_byte_i) : crc_q;
    len_gt  = exp_len_q[31] || (32'(total) > exp_len_q);
    len_eq  = !exp_len_q[31] && (32'(total) == exp_len_q);

    mem_we_o   = 1'b0;
    mem_addr_o = half_q ? (HalfOff + ADDR_W'(offset)) : ADDR_W'(offset);
    mem_data_o = rx_byte_i;

    active_d  = active_q;
    half_d    = half_q;
    fin_d     = fin_q;
    comm_d    = comm_q;
    blk_d     = blk_q;
    exp_len_d = exp_len_q;
    exp_crc_d = exp_crc_q;
    crc_d     = crc_q;
    good_d    = good_q;

    res_valid_o = 1'b0;
    st          = cfr_pkg::ST_ERROR;
    cause       = cfr_pkg::CAUSE_NONE;
    res_crc     = '0;

    if (accept_i) begin
      case (kind_i)
        cfr_pkg::KIND_START: begin
          res_valid_o = 1'b1;
          if (active_q) begin
            cause = cfr_pkg::CAUSE_BUSY;
          end else if ($signed(req_length_i) > $signed(32'(FILE_MAX_BYTES))) begin
            cause = cfr_pkg::CAUSE_TOO_LARGE;
          end else begin
            st        = cfr_pkg::ST_PROGRESS;
            exp_crc_d = expected_crc_i;
            exp_len_d = req_length_i;
            half_d    = (fin_q == 2'd0);
            comm_d    = '0;
            blk_d     = '0;
            crc_d     = '0;
            active_d  = 1'b1;
          end
        end
        cfr_pkg::KIND_CANCEL: begin
          if (active_q) begin
            res_valid_o = 1'b1;
            cause       = cfr_pkg::CAUSE_CANCELLED;
            active_d    = 1'b0;
            blk_d       = '0;
          end
        end
        cfr_pkg::KIND_UNKNOWN: begin
          res_valid_o = 1'b1;
          cause       = cfr_pkg::CAUSE_BAD_CMD;
        end
        default: begin
          if (!active_q) begin
            res_valid_o = block_end_i;
            cause       = cfr_pkg::CAUSE_NO_TRANSFER;
          end else begin
            // Store only bytes inside both the block limit and the file capacity
            mem_we_o = take && (blk_q < BlkMax) && (offset < FileMax);
            crc_d    = crc_new;
            blk_d    = blk_new;
            if (block_end_i) begin
              if (blk_new > BlkMax) begin
                res_valid_o = 1'b1;
                cause       = cfr_pkg::CAUSE_BLOCK_LONG;
                active_d    = 1'b0;
                blk_d       = '0;
              end else if (len_gt || (total > FileMax)) begin
                res_valid_o = 1'b1;
                cause       = cfr_pkg::CAUSE_TOO_MANY;
                active_d    = 1'b0;
                blk_d       = '0;
              end else if (len_eq) begin
                res_valid_o = 1'b1;
                res_crc     = crc_new;
                active_d    = 1'b0;
                blk_d       = '0;
                if (crc_new != exp_crc_q) begin
                  cause = cfr_pkg::CAUSE_CRC;
                end else begin
                  st     = cfr_pkg::ST_SUCCESS;
                  fin_d  = (fin_q == 2'd0) ? 2'd1 : 2'd0;
                  good_d = LEN_W'(total);
                  comm_d = '0;
                end
              end else begin
                comm_d = total;
                blk_d  = '0;
              end
            end
          end
        end
      endcase
    end

    res_o.status          = st;
    res_o.error_cause     = cause;
    res_o.finished_buffer = (fin_d == 2'd1);
    res_o.finished_length = 15'(good_d);
    res_o.computed_crc    = res_crc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      half_q    <= 1'b0;
      fin_q     <= cfr_pkg::NO_FINISHED;
      comm_q    <= '0;
      blk_q     <= '0;
      exp_len_q <= '0;
      exp_crc_q <= '0;
      crc_q     <= '0;
      good_q    <= '0;
    end else begin
      active_q  <= active_d;
      half_q    <= half_d;
      fin_q     <= fin_d;
      comm_q    <= comm_d;
      blk_q     <= blk_d;
      exp_len_q <= exp_len_d;
      exp_crc_q <= exp_crc_d;
      crc_q     <= crc_d;
      good_q    <= good_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cfr_skid.sv
`default_nettype none

module cfr_skid (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire cfr_pkg::result_t  push_data_i,
  output logic                   space_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output cfr_pkg::result_t       out_data_o
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  cfr_pkg::result_t out_q, out_d;
  cfr_pkg::result_t skid_q, skid_d;
  logic             pop;

  always_comb begin
    pop          = out_valid_q && out_ready_i;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_d       = push_data_i;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = push_data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
